// ----- hw/rtl/lpht_pkg.sv -----
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int TABLE_SIZE_DEF = 24;
    localparam int MODE_W         = 2;
    localparam int KEY_W          = 7;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int SLOT_W         = 5;

    // operation codes carried on the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DELETE = 2'd2
    } mode_t;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    // per-slot occupancy
    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_USED    = 2'd1,
        SLOT_DELETED = 2'd2
    } slot_state_t;

    // sequencer states
    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_READ  = 2'd1,
        FSM_CHECK = 2'd2
    } fsm_t;

    // write request into the key/value store
    typedef struct packed {
        logic               we;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } store_wr_t;

    // registered read data from the key/value store
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } store_rd_t;

endpackage

// ----- hw/rtl/lpht_store.sv -----
`timescale 1ns / 1ps

module lpht_store
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int IDX_W      = $clog2(TABLE_SIZE)
)
(
    input  logic             clk,
    input  logic [IDX_W-1:0] addr,
    input  store_wr_t        wr,
    output store_rd_t        rd
);

    logic [KEY_W-1:0]   key_mem   [TABLE_SIZE];
    logic [VALUE_W-1:0] value_mem [TABLE_SIZE];
    store_rd_t          rd_reg;

    // single port, read every cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            key_mem[addr]   <= wr.key;
            value_mem[addr] <= wr.value;
        end
        rd_reg.key   <= key_mem[addr];
        rd_reg.value <= value_mem[addr];
    end

    assign rd = rd_reg;

endmodule

// ----- hw/rtl/linear_probe_hash_table_unit.sv -----
`timescale 1ns / 1ps

// channel   signals                                   direction
// input     in_valid, in_ready, mode, key, value      request in
// output    out_valid, out_ready, status, value_out,  result out
//           slot
//
// one transfer in gives one transfer out
// the request is taken and its home slot formed, then each probed slot gets a
// store read, then a compare/update, up to TABLE_SIZE probes
// reset clears every slot to empty at once (state flops), no clearing pass
// a finished result sits in the output register while the next request is
// taken; the sequencer stalls at its final compare only if that register is
// still full

module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [MODE_W-1:0]          mode,
    input  logic [KEY_W-1:0]           key,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  value_out,
    output logic [SLOT_W-1:0]          slot
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    // wide enough for TABLE_SIZE shifted by KEY_W-1
    localparam int REM_W = KEY_W + 9;
    localparam logic [REM_W-1:0] TS_REM = REM_W'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_SIZE - 1);

    // key modulo TABLE_SIZE by shift-and-subtract, one step per key bit
    function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] k);
        logic [REM_W-1:0] r;
        r = REM_W'(k);
        for (int s = KEY_W - 1; s >= 0; s--)
        begin
            if (r >= (TS_REM << s))
            begin
                r = r - (TS_REM << s);
            end
        end
        return IDX_W'(r);
    endfunction

    // sequencer
    fsm_t                state_reg;
    fsm_t                state_next;

    // request being worked on
    mode_t               mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    cnt_reg;

    // slot occupancy, cleared by reset
    slot_state_t         slot_st_reg [TABLE_SIZE];

    // result register
    logic                out_valid_reg;
    status_t             status_reg;
    logic [VALUE_W-1:0]  vout_reg;
    logic [SLOT_W-1:0]   slot_reg;

    // key/value store port
    store_wr_t           wr;
    store_rd_t           rd;

    // probe decision
    slot_state_t         cur_st;
    logic                last_probe;
    logic                key_hit;
    logic                found;
    logic                stop;
    status_t             res_status;
    logic                out_free;
    logic                commit;
    logic                accept;
    logic [IDX_W-1:0]    idx_step;

    lpht_store #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk  (clk),
        .addr (idx_reg),
        .wr   (wr),
        .rd   (rd)
    );

    // compare of one probed slot; store data is valid in FSM_CHECK
    always_comb
    begin
        cur_st     = slot_st_reg[idx_reg];
        last_probe = (cnt_reg == LAST_CNT);
        key_hit    = (cur_st == SLOT_USED) && (rd.key == key_reg);
        case (mode_reg) inside
            MODE_INSERT:
            begin
                found      = (cur_st != SLOT_USED);
                stop       = found || last_probe;
                res_status = found ? STAT_DONE : STAT_FULL;
            end
            MODE_SEARCH, MODE_DELETE:
            begin
                found      = key_hit;
                stop       = key_hit || (cur_st == SLOT_EMPTY) || last_probe;
                res_status = found ? STAT_DONE : STAT_NOT_FOUND;
            end
            default:
            begin
                // unused opcode: nothing changes, reports not found
                found      = 1'b0;
                stop       = 1'b1;
                res_status = STAT_NOT_FOUND;
            end
        endcase
    end

    // wrap to slot 0 after the last slot
    assign idx_step = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FSM_READ;
                end
            end
            FSM_READ:
            begin
                state_next = FSM_CHECK;
            end
            FSM_CHECK:
            begin
                if (!stop)
                begin
                    state_next = FSM_READ;
                end
                else if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                in_ready = 1'b1;
            end
            FSM_READ:
            begin
                in_ready = 1'b0;
            end
            FSM_CHECK:
            begin
                commit = stop && out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // insert writes key and value into the chosen slot
    always_comb
    begin
        wr.we    = commit && found && (mode_reg == MODE_INSERT);
        wr.key   = key_reg;
        wr.value = value_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                slot_st_reg[i] <= SLOT_EMPTY;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // mark the slot taken or turned into a tombstone
            if (commit && found)
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    slot_st_reg[idx_reg] <= SLOT_USED;
                end
                else if (mode_reg == MODE_DELETE)
                begin
                    slot_st_reg[idx_reg] <= SLOT_DELETED;
                end
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode_t'(mode);
            key_reg   <= key;
            value_reg <= value;
            idx_reg   <= home_slot(key);
            cnt_reg   <= '0;
        end
        else if ((state_reg == FSM_CHECK) && !stop)
        begin
            idx_reg <= idx_step;
            cnt_reg <= cnt_reg + 1'b1;
        end

        if (commit)
        begin
            status_reg <= res_status;
            // a found search or delete returns the stored value, all else returns zero
            vout_reg   <= (found && (mode_reg != MODE_INSERT)) ? rd.value : '0;
            slot_reg   <= found ? SLOT_W'(idx_reg) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = vout_reg;
    assign slot      = slot_reg;

endmodule

// ----- dv/lpht_tb_pkg.sv -----
`timescale 1ns / 1ps

package lpht_tb_pkg;

    import lpht_pkg::*;

    // the one mode code the block leaves unused
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    class hash_table_scoreboard;

        typedef struct {
            logic [STATUS_W-1:0] status;
            logic [VALUE_W-1:0]  value;
            logic [SLOT_W-1:0]   slot;
        } outcome_t;

        // shadow copy of the table
        slot_state_t        slot_state [TABLE_SIZE_DEF];
        logic [KEY_W-1:0]   slot_key   [TABLE_SIZE_DEF];
        logic [VALUE_W-1:0] slot_value [TABLE_SIZE_DEF];

        outcome_t pending_outcomes [$];

        int errors;
        int mode_count [4];
        int full_count;
        int miss_count;
        int full_pass_misses;
        int tombstone_reuses;

        function new();
            foreach (slot_state[i])
            begin
                slot_state[i] = SLOT_EMPTY;
                slot_key[i]   = '0;
                slot_value[i] = '0;
            end
            errors           = 0;
            full_count       = 0;
            miss_count       = 0;
            full_pass_misses = 0;
            tombstone_reuses = 0;
            foreach (mode_count[i])
                mode_count[i] = 0;
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        // key of a randomly chosen used slot, or -1 if the table holds none
        function int pick_live_key();
            int used_count;
            int target;
            used_count = 0;
            foreach (slot_state[i])
                if (slot_state[i] == SLOT_USED)
                    used_count++;
            if (used_count == 0)
                return -1;
            target = $urandom_range(0, used_count - 1);
            foreach (slot_state[i])
            begin
                if (slot_state[i] == SLOT_USED)
                begin
                    if (target == 0)
                        return int'(slot_key[i]);
                    target--;
                end
            end
            return -1;
        endfunction

        // apply one accepted request to the shadow table and queue its outcome
        function void note_request(logic [MODE_W-1:0] op, logic [KEY_W-1:0] k,
                                   logic [VALUE_W-1:0] v);
            outcome_t    res;
            int unsigned idx;
            int          n;
            bit          found;
            res.status = STAT_NOT_FOUND;
            res.value  = '0;
            res.slot   = '0;
            found      = 1'b0;
            idx        = k % TABLE_SIZE_DEF;
            mode_count[op]++;
            case (op)
                MODE_INSERT:
                begin
                    res.status = STAT_FULL;
                    for (n = 0; n < TABLE_SIZE_DEF; n++)
                    begin
                        if (slot_state[idx] != SLOT_USED)
                        begin
                            if (slot_state[idx] == SLOT_DELETED)
                                tombstone_reuses++;
                            slot_state[idx] = SLOT_USED;
                            slot_key[idx]   = k;
                            slot_value[idx] = v;
                            res.status      = STAT_DONE;
                            res.slot        = SLOT_W'(idx);
                            break;
                        end
                        idx = (idx == TABLE_SIZE_DEF - 1) ? 0 : idx + 1;
                    end
                end
                MODE_SEARCH, MODE_DELETE:
                begin
                    for (n = 0; n < TABLE_SIZE_DEF; n++)
                    begin
                        if (slot_state[idx] == SLOT_EMPTY)
                            break;
                        if (slot_state[idx] == SLOT_USED && slot_key[idx] == k)
                        begin
                            found      = 1'b1;
                            res.status = STAT_DONE;
                            res.value  = slot_value[idx];
                            res.slot   = SLOT_W'(idx);
                            if (op == MODE_DELETE)
                                slot_state[idx] = SLOT_DELETED;
                            break;
                        end
                        idx = (idx == TABLE_SIZE_DEF - 1) ? 0 : idx + 1;
                    end
                    if (!found && n == TABLE_SIZE_DEF)
                        full_pass_misses++;
                end
                default:
                    ;
            endcase
            if (res.status == STAT_FULL)
                full_count++;
            if (res.status == STAT_NOT_FOUND)
                miss_count++;
            pending_outcomes.push_back(res);
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] exp_v,
                                    logic [VALUE_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] vo,
                                   logic [SLOT_W-1:0] sl);
            outcome_t exp_o;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d value_out %h slot %0d",
                         $time, st, vo, sl);
                errors++;
                return;
            end
            exp_o = pending_outcomes.pop_front();
            compare_field("status", VALUE_W'(exp_o.status), VALUE_W'(st));
            compare_field("value_out", exp_o.value, vo);
            compare_field("slot", VALUE_W'(exp_o.slot), VALUE_W'(sl));
        endfunction

    endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import lpht_pkg::*;
    import lpht_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int MAX_GAP      = 8;
    // receiver hold-off, long enough to back the block up into its input
    localparam int LONG_HOLD    = 200;
    // end-of-run idle wait, longer than the worst probe chain with margin
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef enum int { PH_FILL, PH_CHURN, PH_DRAIN } phase_t;

    typedef struct packed {
        logic [MODE_W-1:0]  op;
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
    } request_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [MODE_W-1:0]         mode      = '0;
    logic [KEY_W-1:0]          key       = '0;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value_out;
    logic [SLOT_W-1:0]         slot;

    // no-idle stretch, shared by sender and receiver
    bit          burst       = 1'b0;
    int unsigned cycle_count = 0;

    hash_table_scoreboard sb;

    linear_probe_hash_table_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .value_out (value_out),
        .slot      (slot)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL linear_probe_hash_table_unit");
            $finish;
        end
    end

    // directed opening, table starts empty
    //   misses on an empty table, extreme keys and values, a collision chain
    //   at home slot 0, tombstone skipped by search then reused by insert,
    //   duplicate key where the first match wins, the unused mode, double
    //   delete, and a chain that wraps from the last slot to slot 0
    request_t directed_reqs [22] = '{
        '{MODE_SEARCH, 7'd5,   32'h0000_0000},
        '{MODE_DELETE, 7'd5,   32'h0000_0000},
        '{MODE_INSERT, 7'd0,   32'h8000_0000},
        '{MODE_INSERT, 7'd127, 32'h7fff_ffff},
        '{MODE_INSERT, 7'd24,  32'h0000_0000},
        '{MODE_INSERT, 7'd48,  32'hffff_ffff},
        '{MODE_SEARCH, 7'd48,  32'h0000_0000},
        '{MODE_DELETE, 7'd24,  32'h0000_0000},
        '{MODE_SEARCH, 7'd48,  32'h0000_0000},
        '{MODE_SEARCH, 7'd24,  32'h0000_0000},
        '{MODE_INSERT, 7'd72,  32'h5555_5555},
        '{MODE_INSERT, 7'd0,   32'haaaa_aaaa},
        '{MODE_SEARCH, 7'd0,   32'h0000_0000},
        '{MODE_DELETE, 7'd0,   32'h0000_0000},
        '{MODE_SEARCH, 7'd0,   32'h0000_0000},
        '{MODE_UNUSED, 7'd127, 32'hffff_ffff},
        '{MODE_SEARCH, 7'd127, 32'h0000_0000},
        '{MODE_DELETE, 7'd127, 32'h0000_0000},
        '{MODE_DELETE, 7'd127, 32'h0000_0000},
        '{MODE_INSERT, 7'd23,  32'h0000_0001},
        '{MODE_INSERT, 7'd47,  32'h0000_0002},
        '{MODE_SEARCH, 7'd47,  32'h0000_0000}
    };

    // one request transfer; valid stays high afterward so a back-to-back
    // request can follow without dropping it in the same step
    task automatic send_request(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k,
                                input logic [VALUE_W-1:0] v, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        key      <= k;
        value    <= v;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_request(op, k, v);
    endtask

    // sender pause: drop valid and wait for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // operation mix depends on the phase: fill drives the table to full,
    // drain empties it and leaves tombstones, churn keeps it in between
    function automatic logic [MODE_W-1:0] draw_mode(phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return MODE_UNUSED;
        case (ph)
            PH_FILL:  return (r < 80) ? MODE_INSERT : (r < 92) ? MODE_SEARCH : MODE_DELETE;
            PH_CHURN: return (r < 40) ? MODE_INSERT : (r < 70) ? MODE_SEARCH : MODE_DELETE;
            default:  return (r < 15) ? MODE_INSERT : (r < 45) ? MODE_SEARCH : MODE_DELETE;
        endcase
    endfunction

    // lookups mostly hit live keys; otherwise keys crowd a few home slots
    // to build long chains and wraps, with some spread over the whole range
    function automatic logic [KEY_W-1:0] draw_key(logic [MODE_W-1:0] op);
        int r;
        int live;
        r    = $urandom_range(0, 99);
        live = sb.pick_live_key();
        if ((op == MODE_SEARCH || op == MODE_DELETE) && live >= 0 && r < 65)
            return KEY_W'(live);
        if (r < 80)
            return KEY_W'($urandom_range(0, 3) + TABLE_SIZE_DEF * $urandom_range(0, 5));
        return KEY_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 39))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // result side: random ready gaps, plus two long hold-offs so the block
    // backs up and stalls its input while the sender keeps offering
    initial
    begin : result_sink
        int gap;
        int results_seen;
        results_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (results_seen == 300 || results_seen == 1200)
                gap = LONG_HOLD;
            else
                gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            sb.check_result(status, value_out, slot);
            results_seen++;
        end
    end

    initial
    begin : request_source
        phase_t            ph;
        int                sent;
        int                phase_idx;
        int                len;
        logic [MODE_W-1:0] op;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_reqs[i])
            send_request(directed_reqs[i].op, directed_reqs[i].k, directed_reqs[i].v,
                         draw_gap());
        wait_drained();

        // random phases; the first one is always a fill phase
        sent      = 0;
        phase_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            ph    = (phase_idx == 0) ? PH_FILL : phase_t'($urandom_range(0, 2));
            burst = ($urandom_range(0, 3) == 0);
            len   = $urandom_range(20, 60);
            for (int i = 0; i < len && sent < RANDOM_ITEMS; i++)
            begin
                op = draw_mode(ph);
                send_request(op, draw_key(op), draw_value(), draw_gap());
                sent++;
            end
            if ($urandom_range(0, 4) == 0)
                wait_drained();
            phase_idx++;
        end

        burst = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d inserts, %0d searches, %0d deletes, %0d unused-mode requests",
                 sb.mode_count[MODE_INSERT], sb.mode_count[MODE_SEARCH],
                 sb.mode_count[MODE_DELETE], sb.mode_count[MODE_UNUSED]);
        $display("saw %0d full-table inserts, %0d misses (%0d after a full pass), %0d tombstone reuses",
                 sb.full_count, sb.miss_count, sb.full_pass_misses, sb.tombstone_reuses);
        if (sb.errors == 0)
            $display("PASS linear_probe_hash_table_unit");
        else
            $display("FAIL linear_probe_hash_table_unit");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_store.sv
hw/rtl/linear_probe_hash_table_unit.sv
dv/lpht_tb_pkg.sv
dv/tb_top.sv
